// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the lexer rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// antecedent at one edge implies consequent at the same edge
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/sbl_pkg.sv
// ---------------------------------------------------------------------------
// sbl_pkg
// types, character codes and helpers for the s-expression byte lexer
// ---------------------------------------------------------------------------
package sbl_pkg;

   // character codes
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;

   // input kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_EOF  = 1'b1;

   // token kinds
   localparam logic TOK_PAREN  = 1'b0;
   localparam logic TOK_SYMBOL = 1'b1;

   // result queue sizing
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_SYMBOL  = 3'd2,
      MODE_QUOTED  = 3'd3,
      MODE_ESCAPE  = 3'd4
   } mode_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic       token_kind;
      logic       quoted;
      logic       char_present;
      logic [7:0] char_value;
      logic       first_of_token;
      logic       last_of_token;
      logic       last_of_run;
   } rsp_type;

   // results of one item, in delivery order
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      push_type   push;
      mode_type   mode;
      logic       empty;
   } step_type;

   function automatic rsp_type make_rsp(input logic tk, input logic q, input logic cp,
                                        input logic [7:0] cv, input logic first,
                                        input logic last);
      rsp_type r;
      r.token_kind     = tk;
      r.quoted         = q;
      r.char_present   = cp;
      r.char_value     = cp ? cv : 8'h00;
      r.first_of_token = first;
      r.last_of_token  = last;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NL);
   endfunction

   function automatic logic is_paren(input logic [7:0] c);
      return (c == CHAR_LPAREN) || (c == CHAR_RPAREN);
   endfunction

endpackage

// File: rtl/core/sbl_step.sv
// ---------------------------------------------------------------------------
// sbl_step
// next lexer mode and up to two result items for one input item
// ---------------------------------------------------------------------------
module sbl_step import sbl_pkg::*; (
   input  mode_type mode,
   input  logic     empty,
   input  req_type  req,
   output step_type step
);

   logic [7:0] c;

   assign c = req.byte_value;

   // mode decision
   always_comb begin
      step.push.count  = 2'd0;
      step.push.first  = '0;
      step.push.second = '0;
      step.mode        = mode;
      step.empty       = empty;
      if (req.kind == KIND_EOF) begin
         case (mode)
            MODE_SYMBOL: begin
               step.push.count = 2'd1;
               step.push.first = make_rsp(TOK_SYMBOL, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
            end
            MODE_QUOTED, MODE_ESCAPE: begin
               step.push.count = 2'd1;
               step.push.first = make_rsp(TOK_SYMBOL, 1'b1, 1'b0, 8'h00, empty, 1'b1);
            end
            default: begin
            end
         endcase
         step.mode  = MODE_IDLE;
         step.empty = 1'b1;
      end else begin
         case (mode)
            MODE_COMMENT: begin
               if (c == CHAR_NL) begin
                  step.mode = MODE_IDLE;
               end
            end
            MODE_SYMBOL: begin
               if (is_space(c)) begin
                  step.push.count = 2'd1;
                  step.push.first = make_rsp(TOK_SYMBOL, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
                  step.mode       = MODE_IDLE;
                  step.empty      = 1'b1;
               end else if (is_paren(c)) begin
                  step.push.count  = 2'd2;
                  step.push.first  = make_rsp(TOK_SYMBOL, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
                  step.push.second = make_rsp(TOK_PAREN, 1'b0, 1'b1, c, 1'b1, 1'b1);
                  step.mode        = MODE_IDLE;
                  step.empty       = 1'b1;
               end else begin
                  step.push.count = 2'd1;
                  step.push.first = make_rsp(TOK_SYMBOL, 1'b0, 1'b1, c, 1'b0, 1'b0);
               end
            end
            MODE_QUOTED: begin
               if (c == CHAR_BSLASH) begin
                  step.mode = MODE_ESCAPE;
               end else if (c == CHAR_DQUOTE) begin
                  step.push.count = 2'd1;
                  step.push.first = make_rsp(TOK_SYMBOL, 1'b1, 1'b0, 8'h00, empty, 1'b1);
                  step.mode       = MODE_IDLE;
                  step.empty      = 1'b1;
               end else begin
                  step.push.count = 2'd1;
                  step.push.first = make_rsp(TOK_SYMBOL, 1'b1, 1'b1, c, empty, 1'b0);
                  step.empty      = 1'b0;
               end
            end
            MODE_ESCAPE: begin
               step.push.count = 2'd1;
               step.push.first = make_rsp(TOK_SYMBOL, 1'b1, 1'b1, c, empty, 1'b0);
               step.empty      = 1'b0;
               step.mode       = MODE_QUOTED;
            end
            default: begin
               // between tokens
               step.mode  = MODE_IDLE;
               step.empty = 1'b1;
               if (is_space(c)) begin
               end else if (c == CHAR_SEMI) begin
                  step.mode = MODE_COMMENT;
               end else if (c == CHAR_DQUOTE) begin
                  step.mode = MODE_QUOTED;
               end else if (is_paren(c)) begin
                  step.push.count = 2'd1;
                  step.push.first = make_rsp(TOK_PAREN, 1'b0, 1'b1, c, 1'b1, 1'b1);
               end else begin
                  step.push.count = 2'd1;
                  step.push.first = make_rsp(TOK_SYMBOL, 1'b0, 1'b1, c, 1'b1, 1'b0);
                  step.mode       = MODE_SYMBOL;
                  step.empty      = 1'b0;
               end
            end
         endcase
      end
      // mark the final result of this item
      if (step.push.count == 2'd1) begin
         step.push.first.last_of_run = 1'b1;
      end
      if (step.push.count == 2'd2) begin
         step.push.second.last_of_run = 1'b1;
      end
   end

endmodule

// File: rtl/core/sbl_result_fifo.sv
// ---------------------------------------------------------------------------
// sbl_result_fifo
// small result queue taking up to two items a cycle and giving one when not stalled
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module sbl_result_fifo import sbl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   rsp_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    pop;

   // output side
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= push.second;
      end
   end

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
   `ASSERT_IMPLY(a_push_fits, clock, reset, push.count != 2'd0,
                 (count_ff + FIFO_CNT_W'(push.count)) <= FIFO_CNT_W'(FIFO_DEPTH))

endmodule

// File: rtl/core/sexpr_byte_lexer.sv
// ---------------------------------------------------------------------------
// sexpr_byte_lexer
// streaming s-expression tokenizer: one source byte in, token characters out
// ---------------------------------------------------------------------------
// Input channel req_*: one source byte or an end-of-input marker per item.
// Result channel rsp_*: one token character or end marker per item; an input
// item produces zero, one or two result items, the last flagged last_of_run.
// Both channels hand over an item when valid is high and stall is low.
// The results of an input item enter the result queue when the item is taken
// and reach rsp_* from the queue storage. Throughput: one input item per cycle
// while the result side keeps up; the mode update is a combinational decision
// on the lexer state register. Results pass through a four-entry queue, so a
// symbol closed by a parenthesis (two results) takes two queue entries;
// req_stall rises when fewer than two queue entries are free.
// Reset (synchronous) returns the lexer to between tokens and empties the
// queue. A stalled result stays on rsp_data unchanged until taken; the input
// side keeps accepting until fewer than two queue entries are free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module sexpr_byte_lexer import sbl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   mode_type mode_ff, mode_in;
   logic     empty_ff, empty_in;
   logic     accept;
   logic     room;
   step_type step;
   push_type push;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   sbl_step u_step (
      .mode  (mode_ff),
      .empty (empty_ff),
      .req   (req_data),
      .step  (step)
   );

   // only taken items reach the queue
   always_comb begin
      push       = step.push;
      mode_in    = mode_ff;
      empty_in   = empty_ff;
      if (accept) begin
         mode_in  = step.mode;
         empty_in = step.empty;
      end else begin
         push.count = 2'd0;
      end
   end

   // lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         empty_ff <= 1'b1;
      end else begin
         mode_ff  <= mode_in;
         empty_ff <= empty_in;
      end
   end

   sbl_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `ASSERT_IMPLY(a_escape_from_quoted, clock, reset,
                 (mode_ff == MODE_ESCAPE) && !$past(reset),
                 ($past(mode_ff) == MODE_QUOTED) || ($past(mode_ff) == MODE_ESCAPE))
   `ASSERT_IMPLY(a_nonempty_in_token, clock, reset, !empty_ff,
                 (mode_ff == MODE_SYMBOL) || (mode_ff == MODE_QUOTED) ||
                 (mode_ff == MODE_ESCAPE))
   `ASSERT_IMPLY(a_pair_only_in_symbol, clock, reset, push.count == 2'd2,
                 mode_ff == MODE_SYMBOL)

endmodule

// File: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: sexpr_byte_lexer regression
// Drives source bytes and end-of-input markers through the lexer and checks
// every token character and end marker against a cycle-free token predictor.
// Directed cases cover parentheses, symbols, quoted strings, escapes, comments
// and end of input in every mode; random token streams, byte noise, a
// back-pressure phase and a full-rate phase follow.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import sbl_pkg::*; ();

   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // predictor state and expected token results
   mode_type lex_mode;
   logic     tok_empty;
   rsp_type  expected_tokens[$];

   // stimulus controls
   bit send_gaps_off = 1'b0;
   bit rsp_quiet     = 1'b0;
   int hold_left     = 0;
   int stall_run     = 0;

   // statistics
   int error_count        = 0;
   int items_sent         = 0;
   int eof_items          = 0;
   int input_stall_cycles = 0;
   int paren_tokens       = 0;
   int symbol_chars       = 0;
   int quoted_chars       = 0;
   int end_markers        = 0;
   int cycle_count        = 0;

   sexpr_byte_lexer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // ---------------------------------------------------------------------
   // token predictor
   // ---------------------------------------------------------------------
   function automatic rsp_type build_token(input logic tk, input logic in_quotes,
                                           input logic has_char, input logic [7:0] ch,
                                           input logic first, input logic last);
      rsp_type t;
      t = '{token_kind: tk, quoted: in_quotes, char_present: has_char,
            char_value: (has_char ? ch : 8'h00), first_of_token: first,
            last_of_token: last, last_of_run: 1'b0};
      return t;
   endfunction

   task automatic predict_tokens(input req_type item);
      rsp_type    run_q[$];
      rsp_type    t;
      logic [7:0] c;
      logic       blank;
      logic       paren;
      c     = item.byte_value;
      blank = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NL);
      paren = (c == CHAR_LPAREN) || (c == CHAR_RPAREN);
      if (item.kind == KIND_EOF) begin
         // end of input closes any open token
         eof_items++;
         if (lex_mode == MODE_SYMBOL)
            run_q.push_back(build_token(TOK_SYMBOL, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1));
         else if (lex_mode == MODE_QUOTED || lex_mode == MODE_ESCAPE)
            run_q.push_back(build_token(TOK_SYMBOL, 1'b1, 1'b0, 8'h00, tok_empty, 1'b1));
         lex_mode  = MODE_IDLE;
         tok_empty = 1'b1;
      end else begin
         case (lex_mode)
            MODE_COMMENT: begin
               if (c == CHAR_NL) lex_mode = MODE_IDLE;
            end
            MODE_SYMBOL: begin
               if (blank || paren) begin
                  // symbol closes; a parenthesis also forms its own token
                  run_q.push_back(build_token(TOK_SYMBOL, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1));
                  if (paren)
                     run_q.push_back(build_token(TOK_PAREN, 1'b0, 1'b1, c, 1'b1, 1'b1));
                  lex_mode  = MODE_IDLE;
                  tok_empty = 1'b1;
               end else begin
                  run_q.push_back(build_token(TOK_SYMBOL, 1'b0, 1'b1, c, 1'b0, 1'b0));
               end
            end
            MODE_QUOTED: begin
               if (c == CHAR_BSLASH) begin
                  lex_mode = MODE_ESCAPE;
               end else if (c == CHAR_DQUOTE) begin
                  run_q.push_back(build_token(TOK_SYMBOL, 1'b1, 1'b0, 8'h00, tok_empty, 1'b1));
                  lex_mode  = MODE_IDLE;
                  tok_empty = 1'b1;
               end else begin
                  run_q.push_back(build_token(TOK_SYMBOL, 1'b1, 1'b1, c, tok_empty, 1'b0));
                  tok_empty = 1'b0;
               end
            end
            MODE_ESCAPE: begin
               // escaped byte passes through as it is
               run_q.push_back(build_token(TOK_SYMBOL, 1'b1, 1'b1, c, tok_empty, 1'b0));
               tok_empty = 1'b0;
               lex_mode  = MODE_QUOTED;
            end
            default: begin
               lex_mode  = MODE_IDLE;
               tok_empty = 1'b1;
               if (blank) begin
                  // skipped
               end else if (c == CHAR_SEMI) begin
                  lex_mode = MODE_COMMENT;
               end else if (c == CHAR_DQUOTE) begin
                  lex_mode = MODE_QUOTED;
               end else if (paren) begin
                  run_q.push_back(build_token(TOK_PAREN, 1'b0, 1'b1, c, 1'b1, 1'b1));
               end else begin
                  run_q.push_back(build_token(TOK_SYMBOL, 1'b0, 1'b1, c, 1'b1, 1'b0));
                  lex_mode  = MODE_SYMBOL;
                  tok_empty = 1'b0;
               end
            end
         endcase
      end
      // flag the last result of this item
      foreach (run_q[i]) begin
         t = run_q[i];
         t.last_of_run = (i == run_q.size() - 1);
         expected_tokens.push_back(t);
      end
   endtask

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      error_count++;
      // keep the log readable when the block is badly broken
      if (error_count <= PRINT_LIMIT)
         $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            report_mismatch("result item with nothing expected", rsp_data.char_value, 8'h00);
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_data.token_kind !== want.token_kind)
               report_mismatch("token_kind", 8'(rsp_data.token_kind),
                               8'(want.token_kind));
            if (rsp_data.quoted !== want.quoted)
               report_mismatch("quoted", 8'(rsp_data.quoted), 8'(want.quoted));
            if (rsp_data.char_present !== want.char_present)
               report_mismatch("char_present", 8'(rsp_data.char_present),
                               8'(want.char_present));
            if (rsp_data.char_value !== want.char_value)
               report_mismatch("char_value", rsp_data.char_value, want.char_value);
            if (rsp_data.first_of_token !== want.first_of_token)
               report_mismatch("first_of_token", 8'(rsp_data.first_of_token),
                               8'(want.first_of_token));
            if (rsp_data.last_of_token !== want.last_of_token)
               report_mismatch("last_of_token", 8'(rsp_data.last_of_token),
                               8'(want.last_of_token));
            if (rsp_data.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", 8'(rsp_data.last_of_run),
                               8'(want.last_of_run));
            if (!want.char_present) end_markers++;
            else if (want.token_kind == TOK_PAREN) paren_tokens++;
            else if (want.quoted) quoted_chars++;
            else symbol_chars++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // result side stalls: random segments, a long hold on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (rsp_quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         stall_run = stall_run - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_run = pick_gap();
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sexpr_byte_lexer regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // item sender
   // ---------------------------------------------------------------------
   task automatic send_item(input req_type item);
      int gap;
      gap = send_gaps_off ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(posedge clock);
         if (req_stall) input_stall_cycles++;
      end while (req_stall);
      items_sent++;
      predict_tokens(item);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item('{kind: KIND_BYTE, byte_value: b});
   endtask

   // the byte travels along but is ignored
   task automatic send_eof(input logic [7:0] junk);
      send_item('{kind: KIND_EOF, byte_value: junk});
   endtask

   function automatic logic [7:0] pick_symbol_char();
      logic [7:0] c;
      do begin
         if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
         else c = 8'($urandom_range(8'h61, 8'h7A));
      end while (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NL ||
                 c == CHAR_LPAREN || c == CHAR_RPAREN);
      return c;
   endfunction

   function automatic logic [7:0] pick_quoted_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CHAR_DQUOTE || c == CHAR_BSLASH);
      return c;
   endfunction

   function automatic logic [7:0] pick_special();
      case ($urandom_range(0, 7))
         0: return CHAR_SEMI;
         1: return CHAR_DQUOTE;
         2: return CHAR_BSLASH;
         3: return CHAR_NL;
         4: return CHAR_TAB;
         5: return CHAR_SPACE;
         6: return CHAR_LPAREN;
         default: return CHAR_RPAREN;
      endcase
   endfunction

   // one well-formed piece of source text with random content
   task automatic send_fragment();
      int         len;
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            // symbol with a random terminator
            send_byte(8'($urandom_range(8'h61, 8'h7A)));
            len = $urandom_range(0, 5);
            repeat (len) send_byte(pick_symbol_char());
            case ($urandom_range(0, 5))
               0: send_byte(CHAR_SPACE);
               1: send_byte(CHAR_TAB);
               2: send_byte(CHAR_NL);
               3: send_byte(CHAR_LPAREN);
               4: send_byte(CHAR_RPAREN);
               default: send_eof(8'($urandom_range(0, 255)));
            endcase
         end
         4, 5: begin
            // quoted string, some bytes escaped
            send_byte(CHAR_DQUOTE);
            len = $urandom_range(0, 5);
            repeat (len) begin
               if ($urandom_range(0, 4) == 0) begin
                  send_byte(CHAR_BSLASH);
                  send_byte(8'($urandom_range(0, 255)));
               end else begin
                  send_byte(pick_quoted_char());
               end
            end
            if ($urandom_range(0, 9) == 0) send_eof(8'($urandom_range(0, 255)));
            else send_byte(CHAR_DQUOTE);
         end
         6, 7: begin
            send_byte($urandom_range(0, 1) ? CHAR_LPAREN : CHAR_RPAREN);
         end
         8: begin
            // comment up to newline or end of input
            send_byte(CHAR_SEMI);
            len = $urandom_range(0, 5);
            repeat (len) begin
               c = 8'($urandom_range(0, 255));
               if (c == CHAR_NL) c = CHAR_LPAREN;
               send_byte(c);
            end
            if ($urandom_range(0, 4) == 0) send_eof(8'($urandom_range(0, 255)));
            else send_byte(CHAR_NL);
         end
         default: begin
            len = $urandom_range(1, 3);
            repeat (len) begin
               case ($urandom_range(0, 2))
                  0: send_byte(CHAR_SPACE);
                  1: send_byte(CHAR_TAB);
                  default: send_byte(CHAR_NL);
               endcase
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_parens_and_symbols();
      // symbol closed by a parenthesis: end marker then paren token
      send_byte(CHAR_LPAREN);
      send_byte("a");
      send_byte(CHAR_RPAREN);
      // extreme byte values as symbol characters, closed by tab
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(CHAR_TAB);
      send_byte("b");
      send_byte(CHAR_SPACE);
      // end of input inside a symbol
      send_byte("c");
      send_eof(8'hFF);
   endtask

   task automatic test_quoted_tokens();
      // empty quoted string
      send_byte(CHAR_DQUOTE);
      send_byte(CHAR_DQUOTE);
      // escaped quote is the first character
      send_byte(CHAR_DQUOTE);
      send_byte(CHAR_BSLASH);
      send_byte(CHAR_DQUOTE);
      send_byte(CHAR_DQUOTE);
      // end of input inside a quoted token
      send_byte(CHAR_DQUOTE);
      send_byte("q");
      send_eof(8'h00);
      // end of input with an escape pending
      send_byte(CHAR_DQUOTE);
      send_byte(CHAR_BSLASH);
      send_eof(8'hA5);
   endtask

   task automatic test_comments_and_eof();
      // comment hides parentheses until newline
      send_byte(CHAR_SEMI);
      send_byte(CHAR_LPAREN);
      send_byte(CHAR_NL);
      // end of input in a comment, then while idle
      send_byte(CHAR_SEMI);
      send_eof(8'h5A);
      send_eof(8'hFF);
   endtask

   task automatic test_token_streams(input int target);
      while (items_sent < target) send_fragment();
   endtask

   task automatic test_result_backpressure();
      // receiver holds off while the sender keeps offering symbol characters
      send_gaps_off = 1'b1;
      hold_left     = 60;
      send_byte("p");
      repeat (20) send_byte(pick_symbol_char());
      send_byte(CHAR_RPAREN);
      send_gaps_off = 1'b0;
   endtask

   task automatic test_full_rate(input int count);
      int start;
      send_gaps_off = 1'b1;
      rsp_quiet     = 1'b1;
      start         = items_sent;
      while (items_sent < start + count) send_fragment();
      send_gaps_off = 1'b0;
      rsp_quiet     = 1'b0;
   endtask

   task automatic test_byte_noise(input int count);
      logic [7:0] b;
      repeat (count) begin
         b = $urandom_range(0, 1) ? pick_special() : 8'($urandom_range(0, 255));
         if ($urandom_range(0, 15) == 0) send_eof(b);
         else send_byte(b);
      end
   endtask

   initial begin
      lex_mode  = MODE_IDLE;
      tok_empty = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_parens_and_symbols();
      test_quoted_tokens();
      test_comments_and_eof();
      test_token_streams(330);
      test_result_backpressure();
      test_full_rate(40);
      test_byte_noise(60);

      // drain with the result side open
      rsp_quiet = 1'b1;
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("run covered %0d input items (%0d end of input), %0d input stall cycles",
               items_sent, eof_items, input_stall_cycles);
      $display("results seen: %0d paren, %0d symbol chars, %0d quoted chars, %0d end markers",
               paren_tokens, symbol_chars, quoted_chars, end_markers);
      if (error_count == 0)
         $display("sexpr_byte_lexer regression: pass");
      else
         $display("sexpr_byte_lexer regression: fail");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/sbl_pkg.sv
rtl/core/sbl_step.sv
rtl/core/sbl_result_fifo.sv
rtl/core/sexpr_byte_lexer.sv
tb/tb_top.sv
